// ===== sv/afd_pkg.sv =====
package afd_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
    localparam logic [BYTE_W:0]   SUM_MODULUS = 9'h100;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } t_kind;

endpackage

// ===== sv/afd_if.sv =====
// Byte stream in: one received serial byte per item.
interface afd_in_if;
    logic                       valid;
    logic                       ready;
    logic [afd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result stream out: payload bytes and frame verdicts.
interface afd_out_if;
    logic                       valid;
    logic                       ready;
    logic [afd_pkg::KIND_W-1:0] kind;
    logic [afd_pkg::BYTE_W-1:0] data;
    logic [afd_pkg::BYTE_W-1:0] position;
    logic [afd_pkg::BYTE_W-1:0] frame_length;

    modport source (output valid, output kind, output data, output position,
                    output frame_length, input ready);
    modport sink   (input valid, input kind, input data, input position,
                    input frame_length, output ready);
endinterface

// ===== sv/accessory_frame_deframer.sv =====
// Accessory frame deframer. Takes one received serial byte per item on i_in and
// finds frames of the form FF 55 <len> <len payload bytes> <checksum>; extra FF
// bytes before the 55 keep the sync, anything else restarts the hunt. Header
// bytes give no result. Each payload byte is passed on at once (kind 0) with its
// index in the frame and the announced length; the checksum byte gives one
// verdict item (kind 1 good, kind 2 bad) carrying the received checksum byte.
// A frame is good when len plus all payload bytes plus the checksum is zero
// modulo 256. A zero length skips straight to the checksum. Nothing is
// buffered: the consumer must drop the payload of a frame marked bad. Rate is
// one byte per cycle while o_out is not held off by ready; a byte goes through
// the input register, then the result register. The rate is set by the frame
// state update, which sees one byte per cycle. The input side keeps taking
// bytes while a result waits, as long as the held byte gives no result.
module accessory_frame_deframer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    afd_in_if.sink           i_in,
    afd_out_if.source        o_out
);

    // input register
    logic                       r_in_valid;
    logic [afd_pkg::BYTE_W-1:0] r_in_byte;

    // frame state
    afd_pkg::t_phase            r_phase, n_phase;
    logic [afd_pkg::BYTE_W-1:0] r_len, n_len;
    logic [afd_pkg::BYTE_W-1:0] r_count, n_count;
    logic [afd_pkg::BYTE_W-1:0] r_sum, n_sum;

    // result register
    logic                       r_out_valid;
    afd_pkg::t_kind             r_kind, n_kind;
    logic [afd_pkg::BYTE_W-1:0] r_data;
    logic [afd_pkg::BYTE_W-1:0] r_pos, n_pos;
    logic [afd_pkg::BYTE_W-1:0] r_flen;

    logic                       res_valid;
    logic                       out_load_ok;
    logic                       s1_fire;
    logic [afd_pkg::BYTE_W-1:0] count_inc;
    logic [afd_pkg::BYTE_W-1:0] expect_sum;

    assign out_load_ok = !r_out_valid || o_out.ready;
    // held byte is consumed when it makes no result or the result slot frees
    assign s1_fire     = r_in_valid && (!res_valid || out_load_ok);
    assign i_in.ready  = !r_in_valid || s1_fire;

    assign count_inc  = r_count + 8'd1;
    assign expect_sum = afd_pkg::BYTE_W'(afd_pkg::SUM_MODULUS - {1'b0, r_sum});

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_count   = r_count;
        n_sum     = r_sum;
        n_kind    = afd_pkg::KIND_PAYLOAD;
        n_pos     = r_count;
        res_valid = 1'b0;
        case (r_phase)
            afd_pkg::PH_SYNC2: begin
                if (r_in_byte == afd_pkg::SYNC_SECOND) begin
                    n_phase = afd_pkg::PH_LEN;
                end else if (r_in_byte != afd_pkg::SYNC_FIRST) begin
                    n_phase = afd_pkg::PH_HUNT;
                end
            end
            afd_pkg::PH_LEN: begin
                n_len   = r_in_byte;
                n_sum   = r_in_byte;
                n_count = '0;
                n_phase = (r_in_byte == '0) ? afd_pkg::PH_CHECK : afd_pkg::PH_DATA;
            end
            afd_pkg::PH_DATA: begin
                res_valid = 1'b1;
                n_sum     = r_sum + r_in_byte;
                n_count   = count_inc;
                if (count_inc == r_len) begin
                    n_phase = afd_pkg::PH_CHECK;
                end
            end
            afd_pkg::PH_CHECK: begin
                res_valid = 1'b1;
                n_kind    = (r_in_byte == expect_sum) ? afd_pkg::KIND_GOOD
                                                      : afd_pkg::KIND_BAD;
                n_pos     = '0;
                n_phase   = afd_pkg::PH_HUNT;
            end
            default: begin
                // hunting; unused codes hunt as well
                n_phase = (r_in_byte == afd_pkg::SYNC_FIRST) ? afd_pkg::PH_SYNC2
                                                             : afd_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= afd_pkg::PH_HUNT;
            r_len       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (s1_fire) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_count <= n_count;
                r_sum   <= n_sum;
            end
            if (out_load_ok) begin
                r_out_valid <= s1_fire && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.rx_byte;
        end
        if (out_load_ok && s1_fire && res_valid) begin
            r_kind <= n_kind;
            r_data <= r_in_byte;
            r_pos  <= n_pos;
            r_flen <= r_len;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.data         = r_data;
    assign o_out.position     = r_pos;
    assign o_out.frame_length = r_flen;

    // payload phase always has bytes still to come
    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == afd_pkg::PH_DATA |-> r_count < r_len)
        else $error("payload count reached length in payload phase");

    // payload index stays inside the announced length
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == afd_pkg::KIND_PAYLOAD) |-> r_pos < r_flen)
        else $error("payload index beyond frame length");

    // verdicts carry index zero
    a_verdict_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != afd_pkg::KIND_PAYLOAD) |-> r_pos == '0)
        else $error("verdict with nonzero index");

    // a held byte that needs the result slot waits while the slot is blocked
    a_hold_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && res_valid && !out_load_ok) |=>
            (r_in_valid && $stable(r_in_byte) && $stable(r_phase)))
        else $error("byte consumed while result slot blocked");

endmodule
